[hdl/dpd_pkg.sv]
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared widths, register codes, record types and helpers of the detection
// proposal decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dpd_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int VALUE_W       = 20;
	localparam int CONF_W        = FRACTION_BITS + 1;
	localparam int PROD_W        = 2 * CONF_W;
	localparam int LABEL_W       = 8;
	localparam int INDEX_W       = 16;
	localparam int POS_W         = 9;
	localparam int CLASS_W       = 8;
	localparam int SIZE_W        = 11;
	localparam int EDGE_LO_W     = 19;
	localparam int HALF_W        = VALUE_W + 1;
	localparam int SUM_W         = VALUE_W + 3;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 11;

	localparam logic [CONF_W-1:0] ONE_Q = CONF_W'(1 << FRACTION_BITS);

	localparam logic [CLASS_W-1:0]   CLASS_COUNT_RST = CLASS_W'(80);
	localparam logic [SIZE_W-1:0]    IMAGE_SIZE_RST  = SIZE_W'(320);
	localparam logic [CONF_W-1:0]    OBJ_THR_RST     = CONF_W'(128);
	localparam logic [CONF_W-1:0]    SCORE_THR_RST   = CONF_W'(128);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLASS_COUNT,
		REG_IMAGE_SIZE,
		REG_OBJECT_THRESHOLD,
		REG_SCORE_THRESHOLD
	} reg_index_t;

	// one finished row, handed from the front to the back
	typedef struct packed {
		logic signed [VALUE_W-1:0] center_x;
		logic signed [VALUE_W-1:0] center_y;
		logic signed [VALUE_W-1:0] box_width;
		logic signed [VALUE_W-1:0] box_height;
		logic [CONF_W-1:0]         objectness;
		logic [CONF_W-1:0]         best_score;
		logic [LABEL_W-1:0]        label;
		logic [INDEX_W-1:0]        index;
	} row_rec_t;

	typedef struct packed {
		logic [SIZE_W-1:0] image_size;
		logic [CONF_W-1:0] object_threshold;
		logic [CONF_W-1:0] score_threshold;
	} back_cfg_t;

	typedef struct packed {
		logic [EDGE_LO_W-1:0]      left;
		logic [EDGE_LO_W-1:0]      top;
		logic signed [VALUE_W-1:0] right;
		logic signed [VALUE_W-1:0] bottom;
		logic [CONF_W-1:0]         score;
		logic [LABEL_W-1:0]        label;
		logic [INDEX_W-1:0]        proposal_index;
	} result_t;

	// confidence saturated to [0, one]
	function automatic logic [CONF_W-1:0] sat_unit(input logic signed [VALUE_W-1:0] v);
		logic [CONF_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({{(VALUE_W-CONF_W){1'b0}}, ONE_Q})) begin
			r = ONE_Q;
		end else begin
			r = v[CONF_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/dpd_channels.sv]
// ----------------------------------------------------------------------------
// dpd channels
// Valid/ready channels for row elements in and proposals out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpd_elem_if;
	logic                               valid;
	logic                               ready;
	logic signed [dpd_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface dpd_prop_if;
	logic                                 valid;
	logic                                 ready;
	logic [dpd_pkg::EDGE_LO_W-1:0]        left;
	logic [dpd_pkg::EDGE_LO_W-1:0]        top;
	logic signed [dpd_pkg::VALUE_W-1:0]   right;
	logic signed [dpd_pkg::VALUE_W-1:0]   bottom;
	logic [dpd_pkg::CONF_W-1:0]           score;
	logic [dpd_pkg::LABEL_W-1:0]          label;
	logic [dpd_pkg::INDEX_W-1:0]          proposal_index;

	modport source (output valid, output left, output top, output right, output bottom,
		output score, output label, output proposal_index, input ready);
	modport sink   (input valid, input left, input top, input right, input bottom,
		input score, input label, input proposal_index, output ready);
endinterface

`default_nettype wire

[hdl/dpd_front.sv]
// ----------------------------------------------------------------------------
// dpd_front
// Tracks the row position, keeps box fields and the running class maximum,
// and emits a row record at the last element of each row.
// ----------------------------------------------------------------------------
`default_nettype none

module dpd_front #(
	parameter int MAX_CLASSES = 255
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [dpd_pkg::CLASS_W-1:0]        class_count,
	input  wire logic                               take,
	input  wire logic signed [dpd_pkg::VALUE_W-1:0] value,
	output logic                                    push,
	output dpd_pkg::row_rec_t                       rec
);

	localparam logic [dpd_pkg::CLASS_W-1:0] MAX_C = dpd_pkg::CLASS_W'(MAX_CLASSES);
	localparam logic [dpd_pkg::POS_W-1:0]   POS_FIRST_CLASS = dpd_pkg::POS_W'(5);

	logic [dpd_pkg::POS_W-1:0]          pos_q;
	logic [dpd_pkg::INDEX_W-1:0]        count_q;
	logic signed [dpd_pkg::VALUE_W-1:0] cx_q, cy_q, w_q, h_q;
	logic [dpd_pkg::CONF_W-1:0]         obj_q, best_q;
	logic [dpd_pkg::LABEL_W-1:0]        label_q;

	logic [dpd_pkg::CLASS_W-1:0] classes;
	logic [dpd_pkg::POS_W:0]     row_last;
	logic                        is_class, row_end;
	logic [dpd_pkg::CONF_W-1:0]  sat, best_d;
	logic [dpd_pkg::LABEL_W-1:0] label_d;
	logic [dpd_pkg::POS_W-1:0]   cls;

	always_comb begin
		classes = (class_count > MAX_C) ? MAX_C : class_count;
		if (classes == '0) begin
			classes = dpd_pkg::CLASS_W'(1);
		end
		row_last = (dpd_pkg::POS_W+1)'(4) + {{(dpd_pkg::POS_W+1-dpd_pkg::CLASS_W){1'b0}}, classes};
		is_class = pos_q >= POS_FIRST_CLASS;
		row_end  = is_class && ({1'b0, pos_q} >= row_last);
		sat      = dpd_pkg::sat_unit(value);
		cls      = pos_q - POS_FIRST_CLASS;
		// strict greater-than keeps the lower class on ties
		if (pos_q == POS_FIRST_CLASS) begin
			best_d  = sat;
			label_d = '0;
		end else if (sat > best_q) begin
			best_d  = sat;
			label_d = cls[dpd_pkg::LABEL_W-1:0];
		end else begin
			best_d  = best_q;
			label_d = label_q;
		end
	end

	assign push = take && row_end;

	always_comb begin
		rec.center_x   = cx_q;
		rec.center_y   = cy_q;
		rec.box_width  = w_q;
		rec.box_height = h_q;
		rec.objectness = obj_q;
		rec.best_score = best_d;
		rec.label      = label_d;
		rec.index      = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			count_q <= '0;
		end else if (take) begin
			if (row_end) begin
				pos_q   <= '0;
				count_q <= count_q + 1'b1;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			unique case (pos_q)
				dpd_pkg::POS_W'(0): cx_q  <= value;
				dpd_pkg::POS_W'(1): cy_q  <= value;
				dpd_pkg::POS_W'(2): w_q   <= value;
				dpd_pkg::POS_W'(3): h_q   <= value;
				dpd_pkg::POS_W'(4): obj_q <= sat;
				default: begin
					best_q  <= best_d;
					label_q <= label_d;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/dpd_queue.sv]
// ----------------------------------------------------------------------------
// dpd_queue
// Short first-in first-out queue of row records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dpd_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire dpd_pkg::row_rec_t rec_in,
	output logic                   full,
	input  wire logic              pop,
	output logic                   head_valid,
	output dpd_pkg::row_rec_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	dpd_pkg::row_rec_t  mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full       = cnt_q == CNT_W'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= rec_in;
		end
	end

endmodule

`default_nettype wire

[hdl/dpd_back.sv]
// ----------------------------------------------------------------------------
// dpd_back
// Scores a finished row, applies both thresholds and converts the box to
// clamped corners; two pipeline stages, the second is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpd_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dpd_pkg::back_cfg_t cfg,
	input  wire logic               head_valid,
	input  wire dpd_pkg::row_rec_t  head,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output dpd_pkg::result_t        result
);

	localparam int F  = dpd_pkg::FRACTION_BITS;
	localparam int VW = dpd_pkg::VALUE_W;
	localparam int HW = dpd_pkg::HALF_W;
	localparam int SW = dpd_pkg::SUM_W;
	localparam int PW = dpd_pkg::PROD_W;
	localparam int CW = dpd_pkg::CONF_W;
	localparam logic signed [HW-1:0] LO_MAX = HW'((1 << dpd_pkg::EDGE_LO_W) - 1);
	localparam logic signed [HW-1:0] HI_MIN = -(HW'(1 << (VW - 1)));
	localparam logic [PW:0] ROUND = (PW+1)'(1 << (F - 1));

	// stage 1
	logic                        s1_valid_q;
	logic [PW-1:0]               prod_s1;
	logic [CW-1:0]               obj_s1;
	logic signed [HW-1:0]        x1_s1, y1_s1, x2_s1, y2_s1;
	logic [dpd_pkg::LABEL_W-1:0] label_s1;
	logic [dpd_pkg::INDEX_W-1:0] index_s1;

	logic                        out_valid_q;
	dpd_pkg::result_t            result_q;

	logic adv2, s1_load;

	// corner = floor((2c -+ s + 1) / 2)
	function automatic logic signed [HW-1:0] corner(
		input logic signed [VW-1:0] c,
		input logic signed [VW-1:0] s,
		input logic                 upper
	);
		logic signed [SW-1:0] t;
		if (upper) begin
			t = (SW'(c) <<< 1) + SW'(s) + SW'(1);
		end else begin
			t = (SW'(c) <<< 1) - SW'(s) + SW'(1);
		end
		return t[HW:1];
	endfunction

	function automatic logic [dpd_pkg::EDGE_LO_W-1:0] clamp_lo(input logic signed [HW-1:0] v);
		logic [dpd_pkg::EDGE_LO_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > LO_MAX) begin
			r = LO_MAX[dpd_pkg::EDGE_LO_W-1:0];
		end else begin
			r = v[dpd_pkg::EDGE_LO_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [VW-1:0] clamp_hi(
		input logic signed [HW-1:0] v,
		input logic signed [HW-1:0] upper
	);
		logic signed [HW-1:0] m;
		m = (v > upper) ? upper : v;
		if (m < HI_MIN) begin
			m = HI_MIN;
		end
		return m[VW-1:0];
	endfunction

	logic signed [dpd_pkg::SIZE_W:0] size_m1;
	logic signed [HW-1:0]            upper;
	logic                            pass;
	logic [PW:0]                     rounded;

	always_comb begin
		size_m1 = $signed({1'b0, cfg.image_size}) - (dpd_pkg::SIZE_W+1)'(1);
		upper   = HW'($signed({size_m1, {F{1'b0}}}));
		pass    = (obj_s1 >= cfg.object_threshold)
			&& ({1'b0, prod_s1} >= {1'b0, cfg.score_threshold, {F{1'b0}}});
		rounded = {1'b0, prod_s1} + ROUND;
	end

	assign adv2    = !out_valid_q || out_ready;
	assign s1_load = !s1_valid_q || adv2;
	assign pop     = head_valid && s1_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_load) begin
				s1_valid_q <= head_valid;
			end
			if (adv2) begin
				// dropped rows leave no word behind
				out_valid_q <= s1_valid_q && pass;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1  <= PW'(head.objectness) * PW'(head.best_score);
			obj_s1   <= head.objectness;
			x1_s1    <= corner(head.center_x, head.box_width, 1'b0);
			y1_s1    <= corner(head.center_y, head.box_height, 1'b0);
			x2_s1    <= corner(head.center_x, head.box_width, 1'b1);
			y2_s1    <= corner(head.center_y, head.box_height, 1'b1);
			label_s1 <= head.label;
			index_s1 <= head.index;
		end
		if (adv2 && s1_valid_q) begin
			result_q.left           <= clamp_lo(x1_s1);
			result_q.top            <= clamp_lo(y1_s1);
			result_q.right          <= clamp_hi(x2_s1, upper);
			result_q.bottom         <= clamp_hi(y2_s1, upper);
			result_q.score          <= rounded[F+CW-1:F];
			result_q.label          <= label_s1;
			result_q.proposal_index <= index_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

`default_nettype wire

[hdl/detection_proposal_decode_unit.sv]
// ----------------------------------------------------------------------------
// detection_proposal_decode_unit
// Streams detector rows one element per word and emits thresholded boxes.
// ----------------------------------------------------------------------------
// throughput: one element word per cycle; ready only drops when the row queue
//   is full, i.e. while the proposal output is held back
// path: after the last word of its row a proposal goes through the queue write,
//   the score and corner stage and the output register before it is valid
// reset: arst_n clears row position, row counter, queue and valid flags and
//   loads the register defaults; no clearing pass
`default_nettype none

module detection_proposal_decode_unit #(
	parameter int MAX_CLASSES = 255,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	dpd_elem_if.sink                                elements,
	dpd_prop_if.source                              proposals,
	input  wire logic                               cfg_write,
	input  wire logic [dpd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [dpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [dpd_pkg::CLASS_W-1:0] class_count_q;
	logic [dpd_pkg::SIZE_W-1:0]  image_size_q;
	logic [dpd_pkg::CONF_W-1:0]  obj_thr_q;
	logic [dpd_pkg::CONF_W-1:0]  score_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= dpd_pkg::CLASS_COUNT_RST;
			image_size_q  <= dpd_pkg::IMAGE_SIZE_RST;
			obj_thr_q     <= dpd_pkg::OBJ_THR_RST;
			score_thr_q   <= dpd_pkg::SCORE_THR_RST;
		end else if (cfg_write) begin
			unique case (dpd_pkg::reg_index_t'(cfg_index))
				dpd_pkg::REG_CLASS_COUNT:      class_count_q <= cfg_data[dpd_pkg::CLASS_W-1:0];
				dpd_pkg::REG_IMAGE_SIZE:       image_size_q  <= cfg_data[dpd_pkg::SIZE_W-1:0];
				dpd_pkg::REG_OBJECT_THRESHOLD: obj_thr_q     <= cfg_data[dpd_pkg::CONF_W-1:0];
				dpd_pkg::REG_SCORE_THRESHOLD:  score_thr_q   <= cfg_data[dpd_pkg::CONF_W-1:0];
				default: ;
			endcase
		end
	end

	logic               take, push, full, pop, head_valid;
	dpd_pkg::row_rec_t  rec, head;
	dpd_pkg::back_cfg_t back_cfg;
	dpd_pkg::result_t   result;

	assign elements.ready = !full;
	assign take           = elements.valid && !full;

	dpd_front #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.class_count(class_count_q),
		.take       (take),
		.value      (elements.value),
		.push       (push),
		.rec        (rec)
	);

	dpd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rec_in    (rec),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	always_comb begin
		back_cfg.image_size       = image_size_q;
		back_cfg.object_threshold = obj_thr_q;
		back_cfg.score_threshold  = score_thr_q;
	end

	dpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (back_cfg),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (proposals.valid),
		.out_ready (proposals.ready),
		.result    (result)
	);

	assign proposals.left           = result.left;
	assign proposals.top            = result.top;
	assign proposals.right          = result.right;
	assign proposals.bottom         = result.bottom;
	assign proposals.score          = result.score;
	assign proposals.label          = result.label;
	assign proposals.proposal_index = result.proposal_index;

endmodule

`default_nettype wire
